@@ sv/cqft_pkg.sv @@
// Shared types and constants of the quoted-field CSV tokenizer.
package cqft_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] SEP_RESET = 8'h2C;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_FIELD   = 2'd1;
    localparam logic [1:0] KIND_RECORD  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] token_kind;
    } out_item_t;

    typedef struct packed {
        logic inside_quotes;
        logic quote_seen_pending;
        logic carriage_return_seen;
        logic record_begun;
    } tok_state_t;

endpackage

@@ sv/cqft_decode.sv @@
// Per-byte token decision: next parser state and the token, if any, for one word.
module cqft_decode (
    input  cqft_pkg::tok_state_t state,
    input  cqft_pkg::in_item_t   item,
    input  logic [7:0]           field_separator,
    output cqft_pkg::tok_state_t state_next,
    output logic                 emit,
    output cqft_pkg::out_item_t  token
);
    import cqft_pkg::*;

    logic       go_on;
    logic [7:0] b;

    assign b = item.in_byte;

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        token      = '0;
        go_on      = 1'b1;

        if (item.end_of_input)
        begin
            // Flush: close an open record and return to the start state.
            state_next       = '0;
            emit             = state.record_begun;
            token.token_kind = KIND_RECORD;
        end
        else
        begin
            if (state.carriage_return_seen)
            begin
                state_next.carriage_return_seen = 1'b0;
                if (b == CH_LF)
                begin
                    go_on = 1'b0;
                end
            end

            if (go_on && state.quote_seen_pending)
            begin
                state_next.quote_seen_pending = 1'b0;
                if (b == CH_QUOTE)
                begin
                    // A doubled quote inside a span stands for one quote byte.
                    state_next.record_begun = 1'b1;
                    emit                    = 1'b1;
                    token.out_byte          = CH_QUOTE;
                    token.token_kind        = KIND_CONTENT;
                    go_on                   = 1'b0;
                end
                else
                begin
                    state_next.inside_quotes = 1'b0;
                end
            end

            if (go_on)
            begin
                if (state_next.inside_quotes)
                begin
                    state_next.record_begun = 1'b1;
                    if (b == CH_QUOTE)
                    begin
                        state_next.quote_seen_pending = 1'b1;
                    end
                    else
                    begin
                        emit             = 1'b1;
                        token.out_byte   = b;
                        token.token_kind = KIND_CONTENT;
                    end
                end
                else if (b == CH_QUOTE)
                begin
                    state_next.inside_quotes = 1'b1;
                    state_next.record_begun  = 1'b1;
                end
                else if (b == CH_LF || b == CH_CR)
                begin
                    state_next.carriage_return_seen = (b == CH_CR);
                    state_next.record_begun         = 1'b0;
                    emit                            = 1'b1;
                    token.token_kind                = KIND_RECORD;
                end
                else
                begin
                    state_next.record_begun = 1'b1;
                    emit                    = 1'b1;
                    if (b == field_separator)
                    begin
                        token.token_kind = KIND_FIELD;
                    end
                    else
                    begin
                        token.out_byte   = b;
                        token.token_kind = KIND_CONTENT;
                    end
                end
            end
        end
    end

endmodule

@@ sv/csv_quoted_field_tokenizer_core.sv @@
// Top level of the quoted-field CSV tokenizer: input register, decode, result register.
// A token reaches out_valid after its word passes from the input register through decode into the result register.
// Throughput: one word per cycle unless a token waits on a full result register; the parser
// state updates once per word in the decode step, also for a word that yields no token.
// Reset (rst_n low, asynchronous) empties both registers, clears the parser state
// and sets the field separator to a comma.
module csv_quoted_field_tokenizer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cqft_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cqft_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import cqft_pkg::*;

    logic [7:0] sep_val_reg;

    logic       s1_valid_reg;
    in_item_t   s1_data_reg;

    tok_state_t state_reg;
    tok_state_t state_next;

    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic       emit;
    out_item_t  token;
    logic       out_free;
    logic       s1_go;

    cqft_decode u_decode (
        .state           (state_reg),
        .item            (s1_data_reg),
        .field_separator (sep_val_reg),
        .state_next      (state_next),
        .emit            (emit),
        .token           (token)
    );

    // A word leaves the input register when its token has room, or when it has no token.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (out_free || !emit);
    assign in_ready = !s1_valid_reg || s1_go;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_val_reg <= SEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            sep_val_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go)
            begin
                state_reg <= state_next;
            end
            if (s1_go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_go && emit)
        begin
            out_data_reg <= token;
        end
    end

endmodule

@@ sv/cqft_checker.sv @@
// Port-level checks of the tokenizer core and their binding to it.
module cqft_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input cqft_pkg::out_item_t out_data
);
    import cqft_pkg::*;

    // A waiting result word holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed or dropped while stalled");

    // Field and record marks carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.token_kind == KIND_FIELD ||
                      out_data.token_kind == KIND_RECORD) |-> out_data.out_byte == 8'd0)
        else $error("mark token with nonzero byte");

    // Once reset has been seen at an edge, no result is offered at the next one.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind csv_quoted_field_tokenizer_core cqft_checker u_cqft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
